[hdl/gossip_membership_table_defines.svh]
// Assertion macros for the gossip membership table.
`ifndef GOSSIP_MEMBERSHIP_TABLE_DEFINES_SVH
`define GOSSIP_MEMBERSHIP_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define GMT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define GMT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/gmt_pkg.sv]
// Package: word types, request and status codes, register map of the membership table.
package gmt_pkg;

  localparam logic [1:0] REQ_MERGE = 2'd0;
  localparam logic [1:0] REQ_JOIN  = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  localparam logic [2:0] ST_UPDATED  = 3'd0;
  localparam logic [2:0] ST_INSERTED = 3'd1;
  localparam logic [2:0] ST_STALE    = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_JOINED   = 3'd4;
  localparam logic [2:0] ST_LIST     = 3'd5;

  localparam int          CFG_AW         = 4;
  localparam logic [1:0]  REG_SELF_ID    = 2'd0;
  localparam logic [1:0]  REG_SELF_PORT  = 2'd1;
  localparam logic [1:0]  REG_FAIL_TIME  = 2'd2;
  localparam logic [1:0]  REG_REMOVE_TIME = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] member_id;
    logic [15:0] member_port;
    logic [31:0] member_heartbeat;
    logic [31:0] now;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] entry_id;
    logic [15:0] entry_port;
    logic [31:0] entry_heartbeat;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic [31:0] id;
    logic [15:0] port;
    logic [31:0] heartbeat;
    logic [31:0] stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [31:0] self_id;
    logic [15:0] self_port;
    logic [15:0] fail_time;
    logic [15:0] remove_time;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic in_group;
  } seq_stat_t;

endpackage

[hdl/gmt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module gmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[hdl/gmt_seq.sv]
// Sequencer: merge search, join and tick sweep with compaction over the entry RAM.
module gmt_seq import gmt_pkg::*; #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  in_word_t                         item,
  input  cfg_t                             cfg,
  output logic [$clog2(TABLE_DEPTH)-1:0]   rd_addr,
  input  entry_t                           rd_data,
  output logic                             we,
  output logic [$clog2(TABLE_DEPTH)-1:0]   wr_addr,
  output entry_t                           wr_data,
  input  logic                             out_free,
  output logic                             out_load,
  output out_word_t                        out_word,
  output seq_stat_t                        stat,
  output logic [$clog2(TABLE_DEPTH+1)-1:0] count
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MRD  = 3'd1;
  localparam logic [2:0] S_MCMP = 3'd2;
  localparam logic [2:0] S_RES  = 3'd3;
  localparam logic [2:0] S_TRD  = 3'd4;
  localparam logic [2:0] S_TCMP = 3'd5;
  localparam logic [2:0] S_TEND = 3'd6;

  logic [2:0]    state_r, state_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] wr_idx_r, wr_idx_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [31:0]   own_hb_r, own_hb_nxt;
  logic          in_group_r, in_group_nxt;
  in_word_t      item_r, item_nxt;
  out_word_t     res_r, res_nxt;
  out_word_t     pend_r, pend_nxt;

  logic [31:0] age;
  logic [31:0] limit;
  logic        is_last_idx;
  logic        match;

  assign age         = item_r.now - rd_data.stamp;
  assign limit       = {15'd0, {1'b0, cfg.fail_time} + {1'b0, cfg.remove_time}};
  assign is_last_idx = (CW'(idx_r) + CW'(1)) == count_r;
  assign match       = (rd_data.id == item_r.member_id) && (rd_data.port == item_r.member_port);
  assign rd_addr     = idx_r;

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    wr_idx_nxt   = wr_idx_r;
    count_nxt    = count_r;
    own_hb_nxt   = own_hb_r;
    in_group_nxt = in_group_r;
    item_nxt     = item_r;
    res_nxt      = res_r;
    pend_nxt     = pend_r;
    we           = 1'b0;
    wr_addr      = idx_r;
    wr_data      = rd_data;
    out_load     = 1'b0;
    out_word     = res_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          item_nxt = item;
          idx_nxt  = '0;
          case (item.req_type)
            REQ_MERGE: begin
              res_nxt = '{ST_INSERTED, item.member_id, item.member_port,
                          item.member_heartbeat, 1'b1};
              if (count_r == '0) begin
                we        = 1'b1;
                wr_addr   = '0;
                wr_data   = '{item.member_id, item.member_port,
                              item.member_heartbeat, item.now};
                count_nxt = CW'(1);
                state_nxt = S_RES;
              end else begin
                state_nxt = S_MRD;
              end
            end
            REQ_JOIN: begin
              res_nxt = '{ST_JOINED, cfg.self_id, cfg.self_port, own_hb_r, 1'b1};
              if (!in_group_r) begin
                if (count_r < DEPTH_C) begin
                  we           = 1'b1;
                  wr_addr      = count_r[IW-1:0];
                  wr_data      = '{cfg.self_id, cfg.self_port, own_hb_r, item.now};
                  count_nxt    = count_r + CW'(1);
                  in_group_nxt = 1'b1;
                end else begin
                  res_nxt.status = ST_FULL;
                end
              end
              state_nxt = S_RES;
            end
            REQ_TICK: begin
              if (in_group_r && count_r >= CW'(2)) begin
                state_nxt = S_TRD;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      S_MRD: state_nxt = S_MCMP;

      S_MCMP: begin
        if (match) begin
          if (item_r.member_heartbeat > rd_data.heartbeat) begin
            we                = 1'b1;
            wr_data.heartbeat = item_r.member_heartbeat;
            wr_data.stamp     = item_r.now;
            res_nxt.status    = ST_UPDATED;
          end else begin
            res_nxt.status = ST_STALE;
          end
          state_nxt = S_RES;
        end else if (is_last_idx) begin
          if (count_r < DEPTH_C) begin
            we        = 1'b1;
            wr_addr   = count_r[IW-1:0];
            wr_data   = '{item_r.member_id, item_r.member_port,
                          item_r.member_heartbeat, item_r.now};
            count_nxt = count_r + CW'(1);
          end else begin
            res_nxt.status = ST_FULL;
          end
          state_nxt = S_RES;
        end else begin
          idx_nxt   = idx_r + IW'(1);
          state_nxt = S_MRD;
        end
      end

      S_RES: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      S_TRD: state_nxt = S_TCMP;

      S_TCMP: begin
        if (idx_r == '0) begin
          // own entry: bump heartbeat, always listed
          we                = 1'b1;
          wr_data.heartbeat = own_hb_r + 32'd1;
          own_hb_nxt        = own_hb_r + 32'd1;
          pend_nxt          = '{ST_LIST, rd_data.id, rd_data.port, own_hb_r + 32'd1, 1'b0};
          idx_nxt           = IW'(1);
          wr_idx_nxt        = CW'(1);
          state_nxt         = S_TRD;
        end else if (age > limit) begin
          // removed: not copied down
          idx_nxt   = idx_r + IW'(1);
          state_nxt = is_last_idx ? S_TEND : S_TRD;
        end else if (age <= {16'd0, cfg.fail_time} && !out_free) begin
          state_nxt = S_TCMP;
        end else begin
          we         = 1'b1;
          wr_addr    = wr_idx_r[IW-1:0];
          wr_idx_nxt = wr_idx_r + CW'(1);
          if (age <= {16'd0, cfg.fail_time}) begin
            out_load = 1'b1;
            out_word = pend_r;
            pend_nxt = '{ST_LIST, rd_data.id, rd_data.port, rd_data.heartbeat, 1'b0};
          end
          idx_nxt   = idx_r + IW'(1);
          state_nxt = is_last_idx ? S_TEND : S_TRD;
        end
      end

      S_TEND: begin
        count_nxt = wr_idx_r;
        if (out_free) begin
          out_load      = 1'b1;
          out_word      = pend_r;
          out_word.last = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      count_r    <= '0;
      own_hb_r   <= '0;
      in_group_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      own_hb_r   <= own_hb_nxt;
      in_group_r <= in_group_nxt;
    end
    idx_r    <= idx_nxt;
    wr_idx_r <= wr_idx_nxt;
    item_r   <= item_nxt;
    res_r    <= res_nxt;
    pend_r   <= pend_nxt;
  end

  assign stat.busy     = (state_r != S_IDLE);
  assign stat.in_group = in_group_r;
  assign count         = count_r;

endmodule

[hdl/gossip_membership_table.sv]
// Top level: gossip heartbeat membership table with APB registers and output register.
//
// Input channel in_valid / in_stall / in_data carries one request word: merge a
// gossiped member, join the group, or a time tick. Results leave on
// out_valid / out_stall / out_data; out_data.last marks the final word of a request.
// Registers self_id, self_port, fail_time, remove_time sit at byte addresses
// 0, 4, 8 and 12 of the APB port; write them only while the block is idle.
//
// A merge reads the table one entry at a time, through states MRD and MCMP,
// until it finds the member or passes the last entry. A tick reads, ages and
// compacts every entry through the single RAM read port, and waits whenever
// a listed word finds the output register still full. An idle tick or an
// unknown request is taken without leaving idle and yields no word. One
// request is worked at a time; in_stall is high while a request is in
// progress.
//
// A result word sits in the output register while out_stall is high; the
// sequencer holds its place until the register frees up, so nothing is lost.
// Reset clears the member count, own heartbeat, group flag and registers
// (fail_time 5, remove_time 20); the table RAM is not cleared, as only entries
// below the count are ever read.
module gossip_membership_table import gmt_pkg::*; #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_word_t            in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output out_word_t           out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CFG_AW-1:0]   paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

`include "gossip_membership_table_defines.svh"

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  cfg_t      cfg_r;
  logic      out_valid_r;
  out_word_t out_data_r;

  logic [IW-1:0] rd_addr, wr_addr;
  entry_t        rd_data, wr_data;
  logic          we;
  logic          out_free, out_load;
  out_word_t     out_word;
  seq_stat_t     stat;
  logic [CW-1:0] count;
  logic          in_accept;
  logic          cfg_wr;

  // ---- register file ----
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.self_id     <= '0;
      cfg_r.self_port   <= '0;
      cfg_r.fail_time   <= 16'd5;
      cfg_r.remove_time <= 16'd20;
    end else if (cfg_wr && paddr[1:0] == 2'b00) begin
      case (paddr[3:2])
        REG_SELF_ID:     cfg_r.self_id     <= pwdata;
        REG_SELF_PORT:   cfg_r.self_port   <= pwdata[15:0];
        REG_FAIL_TIME:   cfg_r.fail_time   <= pwdata[15:0];
        REG_REMOVE_TIME: cfg_r.remove_time <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SELF_ID:     prdata = cfg_r.self_id;
      REG_SELF_PORT:   prdata = {16'd0, cfg_r.self_port};
      REG_FAIL_TIME:   prdata = {16'd0, cfg_r.fail_time};
      REG_REMOVE_TIME: prdata = {16'd0, cfg_r.remove_time};
      default:         prdata = '0;
    endcase
  end

  // ---- input side: one request in flight ----
  assign in_stall  = stat.busy;
  assign in_accept = in_valid && !in_stall;

  // ---- entry table ----
  gmt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  gmt_seq #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_accept),
    .item     (in_data),
    .cfg      (cfg_r),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .we       (we),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .out_free (out_free),
    .out_load (out_load),
    .out_word (out_word),
    .stat     (stat),
    .count    (count)
  );

  // ---- output register: frees when empty or its word is taken ----
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (out_load) begin
      out_data_r <= out_word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---- checks ----
  `GMT_ASSERT_NOW(a_count_bound, 1'b1, count <= CW'(TABLE_DEPTH), "member count beyond table depth")
  `GMT_ASSERT_NEXT(a_merge_busy, in_accept && in_data.req_type == REQ_MERGE, stat.busy, "merge accepted but sequencer idle")
  `GMT_ASSERT_NOW(a_group_sticky, 1'b1, !$fell(stat.in_group), "group flag dropped")
  `GMT_ASSERT_NOW(a_load_free, out_load, out_free, "result loaded over a waiting word")

endmodule

[tb/sv/gossip_membership_table_test.sv]
// Testbench for the gossip membership table: directed and random requests, checked word by word.
`timescale 1ns / 100ps

module gossip_membership_table_test;
  import gmt_pkg::*;

  localparam int DEPTH = 32;
  localparam longint LIMIT_CYCLES = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #4 clk = ~clk;

  // DUT ports
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_data;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  gossip_membership_table #(.TABLE_DEPTH(DEPTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Shadow of the table, kept in step with accepted words
  logic [31:0] tbl_id [DEPTH];
  logic [15:0] tbl_port [DEPTH];
  logic [31:0] tbl_hb [DEPTH];
  logic [31:0] tbl_stamp [DEPTH];
  int unsigned tbl_count;
  logic [31:0] own_hb;
  bit joined;
  logic [31:0] my_id;
  logic [15:0] my_port;
  logic [15:0] fail_ticks, remove_ticks;

  in_word_t pending_words[$];
  out_word_t expected_words[$];

  int unsigned idle_pct = 0;     // sender gap chance, percent
  int unsigned stall_pct = 0;    // receiver stall chance, percent
  int errors = 0;
  int words_seen = 0;
  int lists_seen = 0;
  longint cycles = 0;

  function automatic out_word_t mk_word(logic [2:0] st, logic [31:0] id, logic [15:0] port,
                                        logic [31:0] hb, logic lst);
    out_word_t w;
    w.status = st; w.entry_id = id; w.entry_port = port;
    w.entry_heartbeat = hb; w.last = lst;
    return w;
  endfunction

  function automatic void queue_req(in_word_t w);
    pending_words = {pending_words, w};
  endfunction

  function automatic void expect_word(out_word_t w);
    expected_words = {expected_words, w};
  endfunction

  // Predict the words one request produces and update the shadow table
  task automatic predict_request(in_word_t r);
    int unsigned i, wr;
    logic [2:0] st;
    logic [16:0] drop_age;
    case (r.req_type)
      REQ_MERGE: begin
        for (i = 0; i < tbl_count; i++)
          if (tbl_id[i] == r.member_id && tbl_port[i] == r.member_port) break;
        if (i < tbl_count) begin
          if (r.member_heartbeat > tbl_hb[i]) begin
            tbl_hb[i] = r.member_heartbeat; tbl_stamp[i] = r.now; st = ST_UPDATED;
          end else st = ST_STALE;
        end else if (tbl_count < DEPTH) begin
          tbl_id[tbl_count] = r.member_id; tbl_port[tbl_count] = r.member_port;
          tbl_hb[tbl_count] = r.member_heartbeat; tbl_stamp[tbl_count] = r.now;
          tbl_count++; st = ST_INSERTED;
        end else st = ST_FULL;
        expect_word(mk_word(st, r.member_id, r.member_port, r.member_heartbeat, 1'b1));
      end
      REQ_JOIN: begin
        st = ST_JOINED;
        if (!joined) begin
          if (tbl_count < DEPTH) begin
            tbl_id[tbl_count] = my_id; tbl_port[tbl_count] = my_port;
            tbl_hb[tbl_count] = own_hb; tbl_stamp[tbl_count] = r.now;
            tbl_count++; joined = 1'b1;
          end else st = ST_FULL;
        end
        expect_word(mk_word(st, my_id, my_port, own_hb, 1'b1));
      end
      REQ_TICK: begin
        if (joined && tbl_count >= 2) begin
          drop_age = {1'b0, fail_ticks} + {1'b0, remove_ticks};
          wr = 1;
          for (i = 1; i < tbl_count; i++) begin
            if ({15'd0, r.now - tbl_stamp[i]} > {32'd0, drop_age}) continue;
            tbl_id[wr] = tbl_id[i]; tbl_port[wr] = tbl_port[i];
            tbl_hb[wr] = tbl_hb[i]; tbl_stamp[wr] = tbl_stamp[i];
            wr++;
          end
          tbl_count = wr;
          own_hb = own_hb + 1;
          tbl_hb[0] = own_hb;
          for (i = 0; i < tbl_count; i++)
            if (i == 0 || (r.now - tbl_stamp[i]) <= {16'd0, fail_ticks}) begin
              expect_word(mk_word(ST_LIST, tbl_id[i], tbl_port[i], tbl_hb[i], 1'b0));
            end
          expected_words[$].last = 1'b1;
        end
      end
      default: ;  // unknown request: ignored
    endcase
  endtask

  // Driver: presents queued words, holds them while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) predict_request(in_data);
      if (pending_words.size() > 0 && $urandom_range(99) >= idle_pct) begin
        in_data <= pending_words.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each accepted result word against the oldest expectation
  always @(posedge clk) begin
    out_word_t e;
    cycles++;
    if (rst_n && out_valid && !out_stall) begin
      words_seen++;
      if (expected_words.size() == 0) begin
        $error("unexpected result word %p", out_data);
        errors++;
      end else begin
        e = expected_words.pop_front();
        if (e.status == ST_LIST) lists_seen++;
        if (out_data.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_data.status); errors++;
        end
        if (out_data.entry_id !== e.entry_id) begin
          $error("entry_id: expected %h, got %h", e.entry_id, out_data.entry_id); errors++;
        end
        if (out_data.entry_port !== e.entry_port) begin
          $error("entry_port: expected %h, got %h", e.entry_port, out_data.entry_port);
          errors++;
        end
        if (out_data.entry_heartbeat !== e.entry_heartbeat) begin
          $error("entry_heartbeat: expected %h, got %h", e.entry_heartbeat,
                 out_data.entry_heartbeat);
          errors++;
        end
        if (out_data.last !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, out_data.last); errors++;
        end
      end
    end
    if (rst_n) out_stall <= ($urandom_range(99) < stall_pct);
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("gossip_membership_table_test failed");
      $finish;
    end
  end

  // Register write: setup then access phase
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= CFG_AW'({idx, 2'b00}); pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_SELF_ID: my_id = val;
      REG_SELF_PORT: my_port = val[15:0];
      REG_FAIL_TIME: fail_ticks = val[15:0];
      default: remove_ticks = val[15:0];
    endcase
  endtask

  // Wait until all sent words are taken and answered, plus a drain margin
  task automatic drain;
    wait (pending_words.size() == 0);
    @(posedge clk);
    while (in_valid || expected_words.size() > 0) @(posedge clk);
    repeat (2 * DEPTH + 20) @(posedge clk);
  endtask

  function automatic in_word_t req(logic [1:0] t, logic [31:0] id, logic [31:0] port,
                                   logic [31:0] hb, logic [31:0] now);
    in_word_t w;
    w.req_type = t; w.member_id = id; w.member_port = port[15:0];
    w.member_heartbeat = hb; w.now = now;
    return w;
  endfunction

  // One random session: well-formed gossip around a join, with noise
  task automatic random_session(int unsigned items, logic [31:0] t0);
    logic [31:0] clock_now;
    logic [31:0] ids [8];
    int unsigned k, pick;
    clock_now = t0;
    for (k = 0; k < 8; k++) ids[k] = (k < 6) ? $urandom_range(7) : $urandom;
    queue_req(req(REQ_JOIN, $urandom, $urandom, $urandom, clock_now));
    for (k = 0; k < items; k++) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        clock_now += $urandom_range(3);
        queue_req(req(REQ_MERGE, ids[$urandom_range(7)], $urandom_range(1),
                      $urandom_range(1) ? $urandom_range(40) : $urandom,
                      clock_now));
      end else if (pick < 85) begin
        clock_now += $urandom_range(1) ? $urandom_range(4) : $urandom_range(40);
        queue_req(req(REQ_TICK, $urandom, $urandom, $urandom, clock_now));
      end else if (pick < 92) begin
        queue_req(req(REQ_JOIN, $urandom, $urandom, $urandom, clock_now));
      end else if (pick < 96) begin
        queue_req(req(2'd3, $urandom, $urandom, $urandom, $urandom));
      end else begin
        queue_req(req(REQ_MERGE, $urandom, $urandom, $urandom, $urandom));
      end
    end
  endtask

  initial begin
    int k;
    tbl_count = 0; own_hb = 0; joined = 1'b0;
    my_id = 0; my_port = 0; fail_ticks = 5; remove_ticks = 20;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: merge before join, stale/update, idle tick, join, ageing, full table
    queue_req(req(REQ_TICK, 0, 0, 0, 0));            // idle tick, not joined
    queue_req(req(REQ_MERGE, 32'hFFFF_FFFF, 32'h0000_FFFF, 32'hFFFF_FFFF, 0));
    queue_req(req(REQ_MERGE, 32'hFFFF_FFFF, 32'h0000_FFFF, 32'hFFFF_FFFF, 1)); // stale
    queue_req(req(REQ_MERGE, 0, 0, 0, 2));
    queue_req(req(REQ_MERGE, 0, 0, 1, 3));            // update
    queue_req(req(2'd3, '1, '1, '1, '1));             // unknown request
    drain();
    write_reg(REG_SELF_ID, 32'hFFFF_FFFF);
    write_reg(REG_SELF_PORT, 32'h0000_FFFF);
    write_reg(REG_FAIL_TIME, 0);
    write_reg(REG_REMOVE_TIME, 0);
    queue_req(req(REQ_JOIN, 0, 0, 0, 32'hFFFF_FFF0));
    queue_req(req(REQ_JOIN, 0, 0, 0, 5));             // repeated join
    queue_req(req(REQ_TICK, 0, 0, 0, 3));             // ages by wrap
    queue_req(req(REQ_MERGE, 5, 5, 5, 10));
    queue_req(req(REQ_TICK, 0, 0, 0, 10));
    queue_req(req(REQ_TICK, 0, 0, 0, 11));            // removes member 5
    queue_req(req(REQ_TICK, 0, 0, 0, 12));            // alone: idle
    drain();
    write_reg(REG_FAIL_TIME, 32'h0000_FFFF);
    write_reg(REG_REMOVE_TIME, 32'h0000_FFFF);
    for (k = 0; k < DEPTH + 1; k++)
      queue_req(req(REQ_MERGE, 32'h100 + k, k, k, 20));
    queue_req(req(REQ_TICK, 0, 0, 0, 32'h0001_FFFD)); // 17-bit limit edge
    queue_req(req(REQ_TICK, 0, 0, 0, 32'h0002_0020));
    drain();

    // Random phases with varying idling and registers
    for (k = 0; k < 4; k++) begin
      idle_pct = (k == 1 || k == 3) ? ((k == 3) ? 29 : 79) : 0;
      stall_pct = (k == 2 || k == 3) ? ((k == 3) ? 29 : 79) : 0;
      // clean slate: the old table can still age out via ticks
      write_reg(REG_SELF_ID, $urandom);
      write_reg(REG_SELF_PORT, $urandom);
      write_reg(REG_FAIL_TIME, $urandom_range(1) ? $urandom_range(8) : $urandom_range(65535));
      write_reg(REG_REMOVE_TIME, $urandom_range(1) ? $urandom_range(12) : $urandom_range(65535));
      random_session(67, $urandom);
      drain();
    end

    $display("covered %0d result words, %0d list entries, four idling phases",
             words_seen, lists_seen);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("gossip_membership_table_test passed");
    end else begin
      $display("gossip_membership_table_test failed");
    end
    $finish;
  end
endmodule

[gossip_membership_table.f]
+incdir+hdl
hdl/gmt_pkg.sv
hdl/gmt_ram.sv
hdl/gmt_seq.sv
hdl/gossip_membership_table.sv
tb/sv/gossip_membership_table_test.sv
